>>> rtl/core/chs_pkg.sv
// Shared widths, codes and defaults of the chained hash set.
`default_nettype none
package chs_pkg;

  localparam int KEY_W = 31;
  localparam int ACT_W = 2;
  localparam int CFG_W = 5;
  localparam int ST_W  = 2;

  localparam int DEF_MAX_BUCKETS  = 16;
  localparam int DEF_POOL_ENTRIES = 64;
  localparam int RESET_BUCKETS    = 10;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

endpackage
`default_nettype wire

>>> rtl/core/chs_ifs.sv
// Handshake channel interfaces for requests, responses and configuration.
`default_nettype none
interface chs_req_if;
  logic                      valid;
  logic                      ready;
  logic [chs_pkg::ACT_W-1:0] action;
  logic [chs_pkg::KEY_W-1:0] key_value;
  modport source (output valid, output action, output key_value, input ready);
  modport sink (input valid, input action, input key_value, output ready);
endinterface

interface chs_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [chs_pkg::ST_W-1:0] status;
  modport source (output valid, output found, output status, input ready);
  modport sink (input valid, input found, input status, output ready);
endinterface

interface chs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [chs_pkg::CFG_W-1:0] bucket_count;
  modport source (output valid, output bucket_count, input ready);
  modport sink (input valid, input bucket_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/chained_hash_set_sorted_buckets.sv
// Top level of the chained hash set: sequencer, node pool and bucket memories.
// An item first passes the bit-serial remainder unit, then walks its bucket's chain
// node by node until it meets a key that is not below its own.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset: a sweep over max(POOL_ENTRIES, MAX_BUCKETS) entries chains the free list
// and empties the buckets; no item is taken until it ends.
`default_nettype none
module chained_hash_set_sorted_buckets #(
  parameter int MAX_BUCKETS  = chs_pkg::DEF_MAX_BUCKETS,
  parameter int POOL_ENTRIES = chs_pkg::DEF_POOL_ENTRIES
) (
  input wire logic   clk,
  input wire logic   rst,
  chs_req_if.sink    req,
  chs_rsp_if.source  rsp,
  chs_cfg_if.sink    cfg
);

  localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
  localparam int PIDX_W = $clog2(POOL_ENTRIES);
  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SWEEP  = (POOL_ENTRIES > MAX_BUCKETS) ? POOL_ENTRIES : MAX_BUCKETS;
  localparam int SWP_W  = $clog2(SWEEP);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_ENTRIES);
  localparam logic [chs_pkg::CFG_W-1:0] BKT_RESET = chs_pkg::CFG_W'(
    (MAX_BUCKETS < chs_pkg::RESET_BUCKETS) ? MAX_BUCKETS : chs_pkg::RESET_BUCKETS);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_HRD  = 4'd3;
  localparam logic [3:0] S_HWT  = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_NCMP = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_INS1 = 4'd8;
  localparam logic [3:0] S_INS2 = 4'd9;
  localparam logic [3:0] S_REM2 = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]                state;
  logic [SWP_W-1:0]          init_idx;
  logic [chs_pkg::CFG_W-1:0] bucket_count;
  logic [chs_pkg::CFG_W-1:0] cfg_v;
  logic [PTR_W-1:0]          free_head;
  logic [PTR_W-1:0]          used_count;

  logic [chs_pkg::ACT_W-1:0] act;
  logic [chs_pkg::KEY_W-1:0] key;
  logic [BKT_W-1:0]          bucket;
  logic [PTR_W-1:0]          cur;
  logic [PTR_W-1:0]          prev;
  logic [PTR_W-1:0]          cur_link;
  logic [PTR_W-1:0]          node;
  logic                      eq;
  logic                      res_found;
  logic [chs_pkg::ST_W-1:0]  res_status;

  logic [PTR_W-1:0]          head_mem [MAX_BUCKETS];
  logic [chs_pkg::KEY_W-1:0] key_mem  [POOL_ENTRIES];
  logic [PTR_W-1:0]          link_mem [POOL_ENTRIES];

  logic                      head_we;
  logic [BKT_W-1:0]          head_wa;
  logic [PTR_W-1:0]          head_wd;
  logic [PTR_W-1:0]          head_rd;
  logic                      key_we;
  logic [PIDX_W-1:0]         key_wa;
  logic [chs_pkg::KEY_W-1:0] key_rd;
  logic                      link_we;
  logic [PIDX_W-1:0]         link_wa;
  logic [PTR_W-1:0]          link_wd;
  logic [PIDX_W-1:0]         link_ra;
  logic [PTR_W-1:0]          link_rd;

  logic                      mod_start;
  logic                      mod_done;
  logic [chs_pkg::CFG_W-1:0] mod_rem;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign mod_start = req.valid && req.ready;

  chs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.key_value),
    .divisor  (bucket_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    cfg_v = cfg.bucket_count;
    if (cfg_v == '0) begin
      cfg_v = chs_pkg::CFG_W'(1);
    end else if (32'(cfg_v) > MAX_BUCKETS) begin
      cfg_v = chs_pkg::CFG_W'(MAX_BUCKETS);
    end
  end

  // Memory port steering.
  always_comb begin
    head_we = 1'b0;
    head_wa = bucket;
    head_wd = node;
    key_we  = 1'b0;
    key_wa  = free_head[PIDX_W-1:0];
    link_we = 1'b0;
    link_wa = prev[PIDX_W-1:0];
    link_wd = node;
    link_ra = cur[PIDX_W-1:0];
    unique case (state)
      S_INIT: begin
        head_we = (32'(init_idx) < MAX_BUCKETS);
        head_wa = BKT_W'(init_idx);
        head_wd = NULL_PTR;
        link_we = (32'(init_idx) < POOL_ENTRIES);
        link_wa = PIDX_W'(init_idx);
        link_wd = PTR_W'(init_idx) + PTR_W'(1);
      end
      S_DEC: begin
        link_ra = free_head[PIDX_W-1:0];
        if (act == chs_pkg::ACT_REMOVE && eq) begin
          link_wd = cur_link;
          head_wd = cur_link;
          if (prev == NULL_PTR) begin
            head_we = 1'b1;
          end else begin
            link_we = 1'b1;
          end
        end
      end
      S_INS1: begin
        key_we  = 1'b1;
        link_we = 1'b1;
        link_wa = free_head[PIDX_W-1:0];
        link_wd = cur;
      end
      S_INS2: begin
        if (prev == NULL_PTR) begin
          head_we = 1'b1;
        end else begin
          link_we = 1'b1;
        end
      end
      S_REM2: begin
        link_we = 1'b1;
        link_wa = cur[PIDX_W-1:0];
        link_wd = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key;
    end
    key_rd <= key_mem[cur[PIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_idx     <= '0;
      bucket_count <= BKT_RESET;
      free_head    <= '0;
      used_count   <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready && used_count == '0) begin
        bucket_count <= cfg_v;
      end
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + SWP_W'(1);
          if (init_idx == SWP_W'(SWEEP - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (mod_start) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_HRD;
          end
        end
        S_HRD: begin
          state <= S_HWT;
        end
        S_HWT: begin
          state <= S_NRD;
        end
        S_NRD: begin
          if (cur == NULL_PTR) begin
            state <= S_DEC;
          end else begin
            state <= S_NCMP;
          end
        end
        S_NCMP: begin
          if (key_rd < key) begin
            state <= S_NRD;
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (act == chs_pkg::ACT_INSERT && !eq && free_head != NULL_PTR) begin
            state <= S_INS1;
          end else if (act == chs_pkg::ACT_REMOVE && eq) begin
            state <= S_REM2;
          end else begin
            state <= S_DONE;
          end
        end
        S_INS1: begin
          free_head <= link_rd;
          state     <= S_INS2;
        end
        S_INS2: begin
          used_count <= used_count + PTR_W'(1);
          state      <= S_DONE;
        end
        S_REM2: begin
          free_head  <= cur;
          used_count <= used_count - PTR_W'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        act <= req.action;
        key <= req.key_value;
      end
      S_MOD: begin
        bucket <= BKT_W'(mod_rem);
      end
      S_HWT: begin
        cur  <= head_rd;
        prev <= NULL_PTR;
      end
      S_NRD: begin
        eq <= 1'b0;
      end
      S_NCMP: begin
        if (key_rd < key) begin
          prev <= cur;
          cur  <= link_rd;
        end else begin
          eq       <= (key_rd == key);
          cur_link <= link_rd;
        end
      end
      S_DEC: begin
        res_found <= eq;
        case (act)
          chs_pkg::ACT_INSERT: begin
            if (eq) begin
              res_status <= chs_pkg::ST_DUP;
            end else if (free_head == NULL_PTR) begin
              res_status <= chs_pkg::ST_FULL;
            end else begin
              res_status <= chs_pkg::ST_DONE;
            end
          end
          default: begin
            res_status <= eq ? chs_pkg::ST_DONE : chs_pkg::ST_MISS;
          end
        endcase
      end
      S_INS1: begin
        node <= free_head;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.found  <= res_found;
          rsp.status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  a_free_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((free_head == NULL_PTR) == (used_count == PTR_W'(POOL_ENTRIES))))
    else $error("free list and node count disagree");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_count <= PTR_W'(POOL_ENTRIES))
    else $error("node count beyond pool size");

  a_insert_has_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS1) |-> (free_head != NULL_PTR))
    else $error("insert started with an empty free list");

  a_remove_frees: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM2) |=> (used_count == $past(used_count) - PTR_W'(1)))
    else $error("remove did not release its node");

endmodule
`default_nettype wire

>>> rtl/core/chs_mod.sv
// Bit-serial remainder unit: key modulo bucket count, one key bit per cycle.
`default_nettype none
module chs_mod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [chs_pkg::KEY_W-1:0] dividend,
  input  wire logic [chs_pkg::CFG_W-1:0] divisor,
  output logic                           done,
  output logic [chs_pkg::CFG_W-1:0]      rem
);

  localparam int CNT_W = $clog2(chs_pkg::KEY_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [chs_pkg::KEY_W-1:0] sh;
  logic [chs_pkg::CFG_W:0]   trial;
  logic [chs_pkg::CFG_W:0]   dext;
  logic [chs_pkg::CFG_W-1:0] rem_next;

  always_comb begin
    trial = {rem, sh[chs_pkg::KEY_W-1]};
    dext  = {1'b0, divisor};
    if (trial >= dext) begin
      rem_next = chs_pkg::CFG_W'(trial - dext);
    end else begin
      rem_next = trial[chs_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == CNT_W'(chs_pkg::KEY_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      sh  <= dividend;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      rem <= rem_next;
      sh  <= {sh[chs_pkg::KEY_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire
